>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/pctd_pkg.sv
// ----------------------------------------------------------------------------
// pctd_pkg
// Types and constants shared by the prefix code tree decoder modules.
// ----------------------------------------------------------------------------
package pctd_pkg;

  localparam int CODE_W           = 16;
  localparam int LEN_W            = 5;
  localparam int SYM_W            = 8;
  localparam int NODE_COUNT_DEF   = 256;
  localparam int MAX_CODE_LEN_DEF = 16;
  localparam int QUEUE_DEPTH      = 2;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DECODE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  // One classified request as it waits in the queue.
  typedef struct packed {
    op_e              op;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
    logic [SYM_W-1:0]  sym;
    logic              dbit;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

>>> rtl/pctd_front.sv
// ----------------------------------------------------------------------------
// pctd_front
// Accepts requests, classifies them and clamps the code length for the queue.
// ----------------------------------------------------------------------------
module pctd_front import pctd_pkg::*; #(
  parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF
) (
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              kind_i,
  input  logic [CODE_W-1:0] code_bits_i,
  input  logic [LEN_W-1:0]  code_len_i,
  input  logic [SYM_W-1:0]  symbol_i,
  input  logic              bit_req_i,
  input  qstat_t            qstat_i,
  output logic              push_o,
  output item_t             item_o
);

  logic [LEN_W-1:0] len_clamped;

  // A length beyond the longest supported code is taken as the longest code.
  always_comb begin
    if (int'(code_len_i) > MAX_CODE_LEN) begin
      len_clamped = LEN_W'(MAX_CODE_LEN);
    end else begin
      len_clamped = code_len_i;
    end
  end

  assign in_ready_o  = !qstat_i.full;
  assign push_o      = in_valid_i && !qstat_i.full;
  assign item_o.op   = kind_i ? OP_DECODE : OP_INSERT;
  assign item_o.code = code_bits_i;
  assign item_o.len  = len_clamped;
  assign item_o.sym  = symbol_i;
  assign item_o.dbit = bit_req_i;

endmodule

>>> rtl/pctd_queue.sv
// ----------------------------------------------------------------------------
// pctd_queue
// Short first-in first-out queue between the front and the tree engine.
// ----------------------------------------------------------------------------
module pctd_queue import pctd_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  item_t  item_i,
  input  logic   pop_i,
  output item_t  item_o,
  output qstat_t qstat_o
);

  localparam int PtrW = $clog2(QUEUE_DEPTH);
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  item_t             slot_q [QUEUE_DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign qstat_o.full  = (cnt_q == CntW'(QUEUE_DEPTH));
  assign qstat_o.empty = (cnt_q == '0);
  assign do_push       = push_i && !qstat_o.full;
  assign do_pop        = pop_i && !qstat_o.empty;
  assign item_o        = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

>>> rtl/pctd_back.sv
// ----------------------------------------------------------------------------
// pctd_back
// Tree engine: holds the node table, walks inserts and steps the decoder.
// ----------------------------------------------------------------------------
module pctd_back import pctd_pkg::*; #(
  parameter int NODE_COUNT = NODE_COUNT_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  item_t            item_i,
  input  qstat_t           qstat_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             symbol_valid_o,
  output logic [SYM_W-1:0] decoded_symbol_o,
  output status_e          status_o
);

  localparam int NodeW = $clog2(NODE_COUNT);
  localparam int UsedW = $clog2(NODE_COUNT + 1);
  localparam int EntW  = 2 * NodeW + SYM_W;

  localparam logic [1:0] BK_IDLE  = 2'd0;
  localparam logic [1:0] BK_DLOAD = 2'd1;
  localparam logic [1:0] BK_DSTEP = 2'd2;
  localparam logic [1:0] BK_INS   = 2'd3;

  function automatic logic [NodeW-1:0] ent_left(input logic [EntW-1:0] e);
    return e[EntW-1 -: NodeW];
  endfunction

  function automatic logic [NodeW-1:0] ent_right(input logic [EntW-1:0] e);
    return e[SYM_W+NodeW-1 -: NodeW];
  endfunction

  function automatic logic [SYM_W-1:0] ent_sym(input logic [EntW-1:0] e);
    return e[SYM_W-1:0];
  endfunction

  // Node 0, the root, lives in a register; the memory holds the other nodes.
  logic [EntW-1:0]   node_mem_q [NODE_COUNT];
  logic [EntW-1:0]   rdata_q;
  logic [EntW-1:0]   root_ent_q, root_ent_d;

  logic [1:0]        state_q, state_d;
  logic [NodeW-1:0]  cur_node_q, cur_node_d;
  logic [EntW-1:0]   cur_ent_q, cur_ent_d;
  logic              cur_ok_q, cur_ok_d;
  logic [UsedW-1:0]  used_q, used_d;
  logic [NodeW-1:0]  dec_node_q, dec_node_d;

  logic [NodeW-1:0]  ins_node_q, ins_node_d;
  logic [EntW-1:0]   ins_ent_q, ins_ent_d;
  logic              ins_rd_q, ins_rd_d;
  logic [LEN_W-1:0]  ins_cnt_q, ins_cnt_d;
  logic [CODE_W-1:0] ins_code_q, ins_code_d;
  logic [SYM_W-1:0]  ins_sym_q, ins_sym_d;

  logic              out_vld_q, out_vld_d;
  logic              out_sv_q, out_sv_d;
  logic [SYM_W-1:0]  out_sym_q, out_sym_d;
  status_e           out_st_q, out_st_d;

  logic              rd_en, wr_en, res_ok, emit, res_sv;
  logic [NodeW-1:0]  rd_addr, wr_node;
  logic [EntW-1:0]   wr_data;
  logic [SYM_W-1:0]  res_sym;
  status_e           res_st;

  logic [EntW-1:0]   head_ent, ins_ent, ins_link;
  logic              head_ok, ins_bit;
  logic [NodeW-1:0]  dec_nxt, ins_slot;
  logic [LEN_W-1:0]  ins_idx;
  logic [CODE_W-1:0] ins_code_sh;

  assign res_ok = !out_vld_q || out_ready_i;

  always_comb begin
    head_ent    = (cur_node_q == '0) ? root_ent_q : cur_ent_q;
    head_ok     = (cur_node_q == '0) || cur_ok_q;
    dec_nxt     = item_i.dbit ? ent_right(head_ent) : ent_left(head_ent);
    // A freshly allocated node is held as all zeros in ins_ent_q, never read back.
    ins_ent     = ins_rd_q ? rdata_q : ins_ent_q;
    ins_idx     = ins_cnt_q - LEN_W'(1);
    ins_code_sh = ins_code_q >> ins_idx;
    ins_bit     = ins_code_sh[0];
    ins_slot    = ins_bit ? ent_right(ins_ent) : ent_left(ins_ent);
    if (ins_bit) begin
      ins_link = {ent_left(ins_ent), used_q[NodeW-1:0], ent_sym(ins_ent)};
    end else begin
      ins_link = {used_q[NodeW-1:0], ent_right(ins_ent), ent_sym(ins_ent)};
    end
  end

  always_comb begin
    state_d    = state_q;
    cur_node_d = cur_node_q;
    cur_ent_d  = cur_ent_q;
    cur_ok_d   = cur_ok_q;
    used_d     = used_q;
    dec_node_d = dec_node_q;
    ins_node_d = ins_node_q;
    ins_ent_d  = ins_ent_q;
    ins_rd_d   = ins_rd_q;
    ins_cnt_d  = ins_cnt_q;
    ins_code_d = ins_code_q;
    ins_sym_d  = ins_sym_q;
    pop_o      = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = '0;
    wr_en      = 1'b0;
    wr_node    = '0;
    wr_data    = '0;
    emit       = 1'b0;
    res_sv     = 1'b0;
    res_sym    = '0;
    res_st     = ST_OK;

    case (state_q)
      BK_IDLE: begin
        if (!qstat_i.empty) begin
          if (item_i.op == OP_INSERT) begin
            pop_o      = 1'b1;
            ins_node_d = '0;
            ins_ent_d  = root_ent_q;
            ins_rd_d   = 1'b0;
            ins_cnt_d  = item_i.len;
            ins_code_d = item_i.code;
            ins_sym_d  = item_i.sym;
            state_d    = BK_INS;
          end else if (!head_ok) begin
            // An insert may have changed the current node: fetch it again.
            rd_en   = 1'b1;
            rd_addr = cur_node_q;
            state_d = BK_DLOAD;
          end else if (dec_nxt == '0) begin
            if (res_ok) begin
              pop_o      = 1'b1;
              emit       = 1'b1;
              res_st     = ST_MISSING;
              cur_node_d = '0;
            end
          end else begin
            pop_o      = 1'b1;
            rd_en      = 1'b1;
            rd_addr    = dec_nxt;
            dec_node_d = dec_nxt;
            state_d    = BK_DSTEP;
          end
        end
      end
      BK_DLOAD: begin
        cur_ent_d = rdata_q;
        cur_ok_d  = 1'b1;
        state_d   = BK_IDLE;
      end
      BK_DSTEP: begin
        if (res_ok) begin
          emit    = 1'b1;
          state_d = BK_IDLE;
          if (ent_left(rdata_q) == '0 && ent_right(rdata_q) == '0) begin
            res_sv     = 1'b1;
            res_sym    = ent_sym(rdata_q);
            cur_node_d = '0;
          end else begin
            cur_node_d = dec_node_q;
            cur_ent_d  = rdata_q;
            cur_ok_d   = 1'b1;
          end
        end
      end
      BK_INS: begin
        if (ins_cnt_q == '0) begin
          if (res_ok) begin
            wr_en    = 1'b1;
            wr_node  = ins_node_q;
            wr_data  = {ent_left(ins_ent), ent_right(ins_ent), ins_sym_q};
            emit     = 1'b1;
            cur_ok_d = 1'b0;
            state_d  = BK_IDLE;
          end
        end else if (ins_slot != '0) begin
          ins_node_d = ins_slot;
          rd_en      = 1'b1;
          rd_addr    = ins_slot;
          ins_rd_d   = 1'b1;
          ins_cnt_d  = ins_cnt_q - LEN_W'(1);
        end else if (used_q >= UsedW'(NODE_COUNT)) begin
          // Table full: the node is written back so that a fresh one reads as a leaf.
          if (res_ok) begin
            wr_en    = 1'b1;
            wr_node  = ins_node_q;
            wr_data  = ins_ent;
            emit     = 1'b1;
            res_st   = ST_FULL;
            cur_ok_d = 1'b0;
            state_d  = BK_IDLE;
          end
        end else begin
          wr_en      = 1'b1;
          wr_node    = ins_node_q;
          wr_data    = ins_link;
          used_d     = used_q + UsedW'(1);
          ins_node_d = used_q[NodeW-1:0];
          ins_ent_d  = '0;
          ins_rd_d   = 1'b0;
          ins_cnt_d  = ins_cnt_q - LEN_W'(1);
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_comb begin
    root_ent_d = root_ent_q;
    if (wr_en && wr_node == '0) begin
      root_ent_d = wr_data;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    out_sv_d  = out_sv_q;
    out_sym_d = out_sym_q;
    out_st_d  = out_st_q;
    if (emit) begin
      out_vld_d = 1'b1;
      out_sv_d  = res_sv;
      out_sym_d = res_sym;
      out_st_d  = res_st;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= BK_IDLE;
      cur_node_q <= '0;
      cur_ok_q   <= 1'b0;
      used_q     <= UsedW'(1);
      root_ent_q <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      cur_node_q <= cur_node_d;
      cur_ok_q   <= cur_ok_d;
      used_q     <= used_d;
      root_ent_q <= root_ent_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_ent_q  <= cur_ent_d;
    dec_node_q <= dec_node_d;
    ins_node_q <= ins_node_d;
    ins_ent_q  <= ins_ent_d;
    ins_rd_q   <= ins_rd_d;
    ins_cnt_q  <= ins_cnt_d;
    ins_code_q <= ins_code_d;
    ins_sym_q  <= ins_sym_d;
    out_sv_q   <= out_sv_d;
    out_sym_q  <= out_sym_d;
    out_st_q   <= out_st_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en && wr_node != '0) begin
      node_mem_q[wr_node] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= node_mem_q[rd_addr];
    end
  end

  assign out_valid_o      = out_vld_q;
  assign symbol_valid_o   = out_sv_q;
  assign decoded_symbol_o = out_sym_q;
  assign status_o         = out_st_q;

endmodule

>>> rtl/prefix_code_tree_decoder_top.sv
// ----------------------------------------------------------------------------
// prefix_code_tree_decoder_top
// Bitwise prefix code tree: builds the tree from inserted codes, decodes bits.
// ----------------------------------------------------------------------------
// Requests arrive on the input channel (in_valid_i / in_ready_o). An insert
// request carries a code, its length and a symbol; a decode request carries one
// bit. Every request gives exactly one result on the output channel
// (out_valid_o / out_ready_i) with a symbol flag, the symbol and a status.
// Requests pass through a two-entry queue to the tree engine, so the input side
// keeps taking requests while a result waits in the output register.
// A decode bit is dispatched and then completed by the registered read of the
// child node; a missing branch is reported at dispatch. The first bit after an
// insert, when the decoder is off the root, first re-reads the current node.
// An insert is dispatched, walks the tree one level per code bit and then
// writes the symbol or reports a full table.
// Reset empties the queue, leaves only the root in the table and puts the
// decoder at the root; no clearing pass is needed, since a node is written when
// it is allocated. When the receiver stalls, the engine holds its next result
// and the queue fills, after which in_ready_o falls.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module prefix_code_tree_decoder_top import pctd_pkg::*; #(
  parameter int NODE_COUNT   = NODE_COUNT_DEF,
  parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              kind_i,
  input  logic [CODE_W-1:0] code_bits_i,
  input  logic [LEN_W-1:0]  code_len_i,
  input  logic [SYM_W-1:0]  symbol_i,
  input  logic              bit_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              symbol_valid_o,
  output logic [SYM_W-1:0]  decoded_symbol_o,
  output logic [1:0]        status_o
);

  logic    push, pop;
  item_t   push_item, head_item;
  qstat_t  qstat;
  status_e status;

  pctd_front #(
    .MAX_CODE_LEN(MAX_CODE_LEN)
  ) u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .kind_i     (kind_i),
    .code_bits_i(code_bits_i),
    .code_len_i (code_len_i),
    .symbol_i   (symbol_i),
    .bit_req_i  (bit_req_i),
    .qstat_i    (qstat),
    .push_o     (push),
    .item_o     (push_item)
  );

  pctd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (push_item),
    .pop_i  (pop),
    .item_o (head_item),
    .qstat_o(qstat)
  );

  pctd_back #(
    .NODE_COUNT(NODE_COUNT)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .item_i          (head_item),
    .qstat_i         (qstat),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .symbol_valid_o  (symbol_valid_o),
    .decoded_symbol_o(decoded_symbol_o),
    .status_o        (status)
  );

  assign status_o = status;

  `ASSERT_SAME(a_pop_not_empty, pop, !qstat.empty, "engine took a request from an empty queue")
  `ASSERT_SAME(a_sym_zero, out_valid_o && !symbol_valid_o, decoded_symbol_o == '0,
               "symbol not zero without a reached leaf")
  `ASSERT_SAME(a_leaf_ok, out_valid_o && symbol_valid_o, status == ST_OK,
               "leaf reported with an error status")
  `ASSERT_NEXT(a_full_holds, qstat.full && !pop, qstat.full, "queue lost a request")

endmodule
